FILE: src/supply_setpoint_with_overcurrent_trip_defines.svh
// Assertion macros for the supply setpoint block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SUPPLY_SETPOINT_WITH_OVERCURRENT_TRIP_DEFINES_SVH
`define SUPPLY_SETPOINT_WITH_OVERCURRENT_TRIP_DEFINES_SVH

// Checked only outside reset
`define SST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define SST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/sst_pkg.sv
// Shared types, constants and helpers for the supply setpoint block.
// No dependencies; imported by every other file except the defines header.
`timescale 1ns / 1ps

package sst_pkg;

  // Field widths
  localparam int SP_W     = 10;
  localparam int STEP_W   = 6;
  localparam int SAMPLE_W = 8;
  localparam int GAIN_W   = 3;
  localparam int READ_W   = 11;
  localparam int DISP_W   = 11;
  localparam int SUM_W    = 14;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [SP_W-1:0] SP_MAX = '1;

  // Register reset values
  localparam logic [STEP_W-1:0]   STEP_RST   = 6'd6;
  localparam logic [SP_W-1:0]     LIMIT_RST  = 10'd900;
  localparam logic [SP_W-1:0]     PRESET_RST = 10'd300;
  localparam logic [SAMPLE_W-1:0] TRIP_RST   = 8'd13;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 3'd2;

  // Display divide by 6: exact for 10-bit inputs via ceil(2^13/6)
  localparam int DISP_SHIFT = 13;
  localparam int DISP_PROD_W = 23;
  localparam logic [10:0] DISP_RECIP = 11'd1366;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE    = 3'd0,
    REG_UPPER_LIMIT  = 3'd1,
    REG_PRESET_VALUE = 3'd2,
    REG_TRIP_LEVEL   = 3'd3,
    REG_CURRENT_GAIN = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [STEP_W-1:0]   step_size;
    logic [SP_W-1:0]     upper_limit;
    logic [SP_W-1:0]     preset_value;
    logic [SAMPLE_W-1:0] trip_level;
    logic [GAIN_W-1:0]   current_gain;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sense_sample;
    logic                press_up;
    logic                press_down;
    logic                press_preset;
    logic                press_zero;
  } item_t;

  typedef struct packed {
    logic [SP_W-1:0]   dac_code;
    logic [DISP_W-1:0] voltage_display;
    logic [SP_W-1:0]   setpoint_now;
    logic [READ_W-1:0] current_reading;
    logic              reading_updated;
    logic              fault;
  } result_t;

  typedef struct packed {
    logic [SP_W-1:0]   setpoint;
    logic              fault;
    logic [SUM_W-1:0]  sample_sum;
    logic [READ_W-1:0] current_value;
  } core_state_t;

  // (sp / 6) * 10 by reciprocal multiply, then shift-add
  function automatic logic [DISP_W-1:0] volt_display(input logic [SP_W-1:0] sp);
    logic [DISP_PROD_W-1:0] prod;
    logic [7:0]             q;
    prod = DISP_PROD_W'(sp) * DISP_PROD_W'(DISP_RECIP);
    q = prod[DISP_SHIFT +: 8];
    return (DISP_W'(q) << 3) + (DISP_W'(q) << 1);
  endfunction

endpackage

FILE: src/sst_if.sv
// Valid/ready channel interfaces for sample words and result words.
// Depends on sst_pkg for field widths.
`timescale 1ns / 1ps

interface sst_in_if import sst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sense_sample;
  logic                press_up;
  logic                press_down;
  logic                press_preset;
  logic                press_zero;

  modport source (output valid, sense_sample, press_up, press_down, press_preset,
                  press_zero, input ready);
  modport sink   (input valid, sense_sample, press_up, press_down, press_preset,
                  press_zero, output ready);
endinterface

interface sst_out_if import sst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SP_W-1:0]   dac_code;
  logic [DISP_W-1:0] voltage_display;
  logic [SP_W-1:0]   setpoint_now;
  logic [READ_W-1:0] current_reading;
  logic              reading_updated;
  logic              fault;

  modport source (output valid, dac_code, voltage_display, setpoint_now, current_reading,
                  reading_updated, fault, input ready);
  modport sink   (input valid, dac_code, voltage_display, setpoint_now, current_reading,
                  reading_updated, fault, output ready);
endinterface

FILE: src/sst_cfg_regs.sv
// Configuration register file, written through a plain write port.
// Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_cfg_regs import sst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  // Decode write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_reg_e'(cfg_index))
        REG_STEP_SIZE:    cfg_nxt.step_size    = cfg_wdata[STEP_W-1:0];
        REG_UPPER_LIMIT:  cfg_nxt.upper_limit  = cfg_wdata[SP_W-1:0];
        REG_PRESET_VALUE: cfg_nxt.preset_value = cfg_wdata[SP_W-1:0];
        REG_TRIP_LEVEL:   cfg_nxt.trip_level   = cfg_wdata[SAMPLE_W-1:0];
        REG_CURRENT_GAIN: cfg_nxt.current_gain = cfg_wdata[GAIN_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_size    <= STEP_RST;
      cfg_r.upper_limit  <= LIMIT_RST;
      cfg_r.preset_value <= PRESET_RST;
      cfg_r.trip_level   <= TRIP_RST;
      cfg_r.current_gain <= GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: src/sst_step.sv
// Single-pass update for one sample word: keys, trip, averaging, result.
// Depends on sst_pkg; purely combinational.
`timescale 1ns / 1ps

module sst_step import sst_pkg::*; #(
  parameter int AVG_COUNT = 20
) (
  input  cfg_t        cfg,
  input  item_t       item,
  input  core_state_t st,
  input  logic        window_end,
  output core_state_t st_nxt,
  output result_t     res
);

  // floor(sum / AVG_COUNT) as (sum * ceil(2^S / AVG_COUNT)) >> S, exact for SUM_W bits
  localparam int DIV_SHIFT  = SUM_W + $clog2(AVG_COUNT);
  localparam int DIV_MULT_W = SUM_W + 1;
  localparam int PROD_W     = DIV_SHIFT + SUM_W + 1;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT =
    DIV_MULT_W'(((64'd1 << DIV_SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));

  logic [SP_W-1:0]   sp;
  logic [SP_W:0]     sp_add;
  logic              fault;
  logic [SUM_W-1:0]  sum_new;
  logic [PROD_W-1:0] prod;
  logic [READ_W-1:0] avg;
  logic [READ_W-1:0] reading;

  // Setpoint keys in priority order, then the trip check
  always_comb begin
    sp     = st.setpoint;
    fault  = st.fault;
    sp_add = '0;
    if (!st.fault) begin
      if (item.press_up && (sp < cfg.upper_limit)) begin
        sp_add = {1'b0, sp} + (SP_W+1)'(cfg.step_size);
        sp     = sp_add[SP_W] ? SP_MAX : sp_add[SP_W-1:0];
      end
      if (item.press_down && (sp >= SP_W'(cfg.step_size))) begin
        sp = sp - SP_W'(cfg.step_size);
      end
      if (item.press_preset) begin
        sp = cfg.preset_value;
      end
      if (item.press_zero) begin
        sp = '0;
      end
    end
    if (item.sense_sample >= cfg.trip_level) begin
      sp    = '0;
      fault = 1'b1;
    end
  end

  // Running sum and averaged reading; the quotient is the product bits above the shift
  always_comb begin
    sum_new = st.sample_sum + SUM_W'(item.sense_sample);
    prod    = PROD_W'(sum_new) * PROD_W'(DIV_MULT);
    avg     = prod[DIV_SHIFT +: READ_W];
    reading = (cfg.current_gain[0] ? avg : '0)
            + (cfg.current_gain[1] ? (avg << 1) : '0)
            + (cfg.current_gain[2] ? (avg << 2) : '0);
  end

  always_comb begin
    st_nxt.setpoint      = sp;
    st_nxt.fault         = fault;
    st_nxt.sample_sum    = window_end ? '0 : sum_new;
    st_nxt.current_value = window_end ? reading : st.current_value;

    res.dac_code         = st.setpoint;
    res.voltage_display  = volt_display(st.setpoint);
    res.setpoint_now     = sp;
    res.current_reading  = st_nxt.current_value;
    res.reading_updated  = window_end;
    res.fault            = fault;
  end

endmodule

FILE: src/supply_setpoint_with_overcurrent_trip.sv
// Top level of the supply setpoint block with overcurrent trip.
// Depends on sst_pkg, sst_if, sst_cfg_regs, sst_step and the defines header.
`timescale 1ns / 1ps
`include "supply_setpoint_with_overcurrent_trip_defines.svh"

// One sample word in, one result word out. A word is taken into an input
// register; once the output register is free or draining, its whole update
// (keys, trip check, window sum and averaged reading) runs in one pass against
// the state registers and lands in the output register. Throughput is one
// word per clock while the sink keeps out_ch.ready high. The state update
// is the only loop, closed through the state registers and sst_step.
// While a finished result waits for the sink, the input register still takes
// one more word; after that in_ch.ready stays low until the result is taken.
// Configuration registers take effect from the next word; write them only
// while no word is in flight. The fault latch clears only on reset.
module supply_setpoint_with_overcurrent_trip import sst_pkg::*; #(
  parameter int AVG_COUNT = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sst_in_if.sink                in_ch,
  sst_out_if.source             out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVG_COUNT - 1);

  cfg_t        cfg;
  item_t       item_r, item_nxt;
  logic        in_vld_r, in_vld_nxt;
  logic        out_vld_r, out_vld_nxt;
  result_t     res_r, res_nxt, res_calc;
  core_state_t st_r, st_nxt, st_calc;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic        window_end;
  logic        in_acc;
  logic        advance;

  sst_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sst_step #(.AVG_COUNT(AVG_COUNT)) u_step (
    .cfg        (cfg),
    .item       (item_r),
    .st         (st_r),
    .window_end (window_end),
    .st_nxt     (st_calc),
    .res        (res_calc)
  );

  // Handshake: move a word forward when the output slot is free or draining
  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign window_end   = (cnt_r == CNT_LAST);

  // Input register
  always_comb begin
    in_vld_nxt = in_vld_r;
    item_nxt   = item_r;
    if (in_acc) begin
      in_vld_nxt            = 1'b1;
      item_nxt.sense_sample = in_ch.sense_sample;
      item_nxt.press_up     = in_ch.press_up;
      item_nxt.press_down   = in_ch.press_down;
      item_nxt.press_preset = in_ch.press_preset;
      item_nxt.press_zero   = in_ch.press_zero;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  // State and output register, updated once per word
  always_comb begin
    st_nxt      = st_r;
    cnt_nxt     = cnt_r;
    out_vld_nxt = out_vld_r;
    res_nxt     = res_r;
    if (advance) begin
      st_nxt      = st_calc;
      cnt_nxt     = window_end ? '0 : cnt_r + 1'b1;
      out_vld_nxt = 1'b1;
      res_nxt     = res_calc;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
      cnt_r     <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.dac_code        = res_r.dac_code;
  assign out_ch.voltage_display = res_r.voltage_display;
  assign out_ch.setpoint_now    = res_r.setpoint_now;
  assign out_ch.current_reading = res_r.current_reading;
  assign out_ch.reading_updated = res_r.reading_updated;
  assign out_ch.fault           = res_r.fault;

  // Checks
  `SST_ASSERT(a_fault_sticky, st_r.fault |=> st_r.fault, "fault latch dropped")
  `SST_ASSERT(a_fault_zero_sp, st_r.fault |-> (st_r.setpoint == '0), "setpoint nonzero in fault")
  `SST_ASSERT(a_cnt_range, cnt_r <= CNT_LAST, "window counter out of range")
  `SST_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> (!st_r.fault && !out_vld_r), "reset not clean")

endmodule

FILE: sim/sst_setpoint_checker.sv
// Scoreboard for the supply setpoint block: watches both channels and the
// register port, predicts each result word and compares it field by field.
// Depends on sst_pkg and the channel interfaces in sst_if.
`timescale 1ns / 1ps

module sst_setpoint_checker import sst_pkg::*; #(
  parameter int AVG_COUNT = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sst_in_if                     in_mon,
  sst_out_if                    out_mon,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    results_seen,
  output int                    pending_words
);

  localparam int DISP_DIV = 6;
  localparam int DISP_MUL = 10;
  localparam int RAISE_W  = SP_W + 1;

  // Shadow copy of the registers and the block state
  cfg_t              regs;
  logic [SP_W-1:0]   setpoint;
  logic              tripped;
  logic [SUM_W-1:0]  sense_sum;
  int                window_fill;
  logic [READ_W-1:0] reading;

  result_t expected_words[$];

  // One sample period: keys, trip check, window sum, averaged reading
  function automatic result_t advance_period(input item_t w);
    result_t             r;
    logic [SP_W-1:0]     start;
    logic [RAISE_W-1:0]  raised;
    int                  disp;
    int                  avg;
    start = setpoint;
    r.reading_updated = 1'b0;
    sense_sum = sense_sum + SUM_W'(w.sense_sample);

    // keys are dead once the trip has latched
    if (!tripped) begin
      if (w.press_up && setpoint < regs.upper_limit) begin
        raised = RAISE_W'(setpoint) + RAISE_W'(regs.step_size);
        setpoint = (raised > RAISE_W'(SP_MAX)) ? SP_MAX : raised[SP_W-1:0];
      end
      if (w.press_down && setpoint >= SP_W'(regs.step_size))
        setpoint = setpoint - SP_W'(regs.step_size);
      if (w.press_preset)
        setpoint = regs.preset_value;
      if (w.press_zero)
        setpoint = '0;
    end

    if (w.sense_sample >= regs.trip_level) begin
      setpoint = '0;
      tripped = 1'b1;
    end

    // close the averaging window
    if (window_fill + 1 >= AVG_COUNT) begin
      avg = (int'(sense_sum) / AVG_COUNT) * int'(regs.current_gain);
      reading = avg[READ_W-1:0];
      sense_sum = '0;
      window_fill = 0;
      r.reading_updated = 1'b1;
    end else begin
      window_fill++;
    end

    disp = (int'(start) / DISP_DIV) * DISP_MUL;
    r.dac_code = start;
    r.voltage_display = disp[DISP_W-1:0];
    r.setpoint_now = setpoint;
    r.current_reading = reading;
    r.fault = tripped;
    return r;
  endfunction

  function automatic int field_check(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : monitor
    item_t   w;
    result_t got;
    result_t want;
    int      errs;
    errs = 0;
    if (!rst_n) begin
      regs = '{step_size: STEP_RST, upper_limit: LIMIT_RST, preset_value: PRESET_RST,
               trip_level: TRIP_RST, current_gain: GAIN_RST};
      setpoint = '0;
      tripped = 1'b0;
      sense_sum = '0;
      window_fill = 0;
      reading = '0;
      expected_words.delete();
      mismatch_count <= 0;
      results_seen <= 0;
      pending_words <= 0;
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_wr_en) begin
        case (cfg_reg_e'(cfg_index))
          REG_STEP_SIZE:    regs.step_size = cfg_wdata[STEP_W-1:0];
          REG_UPPER_LIMIT:  regs.upper_limit = cfg_wdata[SP_W-1:0];
          REG_PRESET_VALUE: regs.preset_value = cfg_wdata[SP_W-1:0];
          REG_TRIP_LEVEL:   regs.trip_level = cfg_wdata[SAMPLE_W-1:0];
          REG_CURRENT_GAIN: regs.current_gain = cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end

      // result side first, so a word cannot match its own prediction early
      if (out_mon.valid && out_mon.ready) begin
        got.dac_code = out_mon.dac_code;
        got.voltage_display = out_mon.voltage_display;
        got.setpoint_now = out_mon.setpoint_now;
        got.current_reading = out_mon.current_reading;
        got.reading_updated = out_mon.reading_updated;
        got.fault = out_mon.fault;
        results_seen <= results_seen + 1;
        if (expected_words.size() == 0) begin
          $error("result word with no prediction pending");
          errs++;
        end else begin
          want = expected_words.pop_front();
          errs += field_check("dac_code", want.dac_code, got.dac_code);
          errs += field_check("voltage_display", want.voltage_display, got.voltage_display);
          errs += field_check("setpoint_now", want.setpoint_now, got.setpoint_now);
          errs += field_check("current_reading", want.current_reading, got.current_reading);
          errs += field_check("reading_updated", want.reading_updated, got.reading_updated);
          errs += field_check("fault", want.fault, got.fault);
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        w.sense_sample = in_mon.sense_sample;
        w.press_up = in_mon.press_up;
        w.press_down = in_mon.press_down;
        w.press_preset = in_mon.press_preset;
        w.press_zero = in_mon.press_zero;
        expected_words.push_back(advance_period(w));
      end

      mismatch_count <= mismatch_count + errs;
      pending_words <= expected_words.size();
    end
  end

endmodule

FILE: sim/tb_supply_setpoint_with_overcurrent_trip.sv
// Stimulus and verdict for the supply setpoint block with overcurrent trip.
// Depends on sst_pkg, sst_if, the block itself and sst_setpoint_checker.
`timescale 1ns / 1ps

module tb_supply_setpoint_with_overcurrent_trip;
  import sst_pkg::*;

  localparam int AVG_WINDOW  = 20;
  localparam int LATENCY     = 4;
  localparam int STALL_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cfg_t settings;
  bit   calm;
  int   words_sent;
  int   mismatch_count;
  int   results_seen;
  int   pending_words;

  sst_in_if  in_ch ();
  sst_out_if out_ch ();

  supply_setpoint_with_overcurrent_trip #(.AVG_COUNT(AVG_WINDOW)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sst_setpoint_checker #(.AVG_COUNT(AVG_WINDOW)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_seen   (results_seen),
    .pending_words  (pending_words)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic cfg_t make_cfg(input int step, input int limit, input int preset,
                                    input int trip, input int gain);
    cfg_t c;
    c.step_size = STEP_W'(step);
    c.upper_limit = SP_W'(limit);
    c.preset_value = SP_W'(preset);
    c.trip_level = SAMPLE_W'(trip);
    c.current_gain = GAIN_W'(gain);
    return c;
  endfunction

  function automatic item_t keys_word(input int sample, input bit up, input bit down,
                                      input bit preset, input bit zero);
    item_t w;
    w.sense_sample = SAMPLE_W'(sample);
    w.press_up = up;
    w.press_down = down;
    w.press_preset = preset;
    w.press_zero = zero;
    return w;
  endfunction

  // random keys; sample kept under the trip level unless tripping is wanted
  function automatic item_t random_word(input bit may_trip);
    int sample;
    if (may_trip || settings.trip_level == '0)
      sample = $urandom_range(0, 255);
    else
      sample = $urandom_range(0, int'(settings.trip_level) - 1);
    return keys_word(sample, $urandom_range(0, 99) < 40, $urandom_range(0, 99) < 30,
                     $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 8);
  endfunction

  // all registers, upper data bits junk on the narrow ones, plus a dropped write
  task automatic write_regs(input cfg_t c);
    settings = c;
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_STEP_SIZE;
    cfg_wdata <= {4'($urandom), c.step_size};
    @(posedge clk);
    cfg_index <= REG_UPPER_LIMIT;
    cfg_wdata <= c.upper_limit;
    @(posedge clk);
    cfg_index <= REG_PRESET_VALUE;
    cfg_wdata <= c.preset_value;
    @(posedge clk);
    cfg_index <= REG_TRIP_LEVEL;
    cfg_wdata <= {2'($urandom), c.trip_level};
    @(posedge clk);
    cfg_index <= REG_CURRENT_GAIN;
    cfg_wdata <= {7'($urandom), c.current_gain};
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_word(input item_t w);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sense_sample <= w.sense_sample;
    in_ch.press_up <= w.press_up;
    in_ch.press_down <= w.press_down;
    in_ch.press_preset <= w.press_preset;
    in_ch.press_zero <= w.press_zero;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic send_random(input int n, input bit may_trip);
    calm = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < n; k++) send_word(random_word(may_trip));
  endtask

  // wait until every predicted word has come back, then let the pipe settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (results_seen < words_sent) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // result sink with random stalls
  initial begin : result_sink
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 25) stall = pick_gap();
      end
    end
  end

  // give up after a long stretch with no word moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    calm = 1'b0;
    words_sent = 0;
    settings = make_cfg(STEP_RST, LIMIT_RST, PRESET_RST, TRIP_RST, GAIN_RST);
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_STEP_SIZE;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.sense_sample <= '0;
    in_ch.press_up <= 1'b0;
    in_ch.press_down <= 1'b0;
    in_ch.press_preset <= 1'b0;
    in_ch.press_zero <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values, samples under the default trip level
    send_word(keys_word(0, 1, 0, 0, 0));
    send_word(keys_word(12, 1, 0, 0, 0));
    send_word(keys_word(5, 1, 1, 0, 0));
    send_word(keys_word(7, 0, 1, 0, 0));
    send_word(keys_word(3, 0, 0, 1, 0));
    send_word(keys_word(1, 0, 0, 0, 1));
    send_random(50, 1'b0);
    drain();

    // large step, full-scale limit: saturation, underflow guard, key order
    write_regs(make_cfg(63, 1023, 1000, 255, 7));
    send_word(keys_word(0, 0, 0, 0, 1));
    send_word(keys_word(0, 1, 0, 0, 0));
    send_word(keys_word(128, 0, 1, 0, 0));
    send_word(keys_word(64, 0, 1, 0, 0));
    send_word(keys_word(32, 0, 0, 1, 0));
    send_word(keys_word(16, 1, 0, 0, 0));
    send_word(keys_word(8, 1, 0, 0, 0));
    send_word(keys_word(4, 0, 0, 0, 1));
    send_word(keys_word(2, 1, 1, 1, 1));
    send_word(keys_word(1, 1, 1, 0, 0));
    send_word(keys_word(127, 1, 0, 1, 0));
    send_word(keys_word(85, 0, 1, 0, 1));
    send_word(keys_word(254, 0, 0, 0, 0));
    send_random(60, 1'b0);
    drain();

    // zero step, zero limit, zero preset, zero gain
    write_regs(make_cfg(0, 0, 0, 255, 0));
    send_random(40, 1'b0);
    drain();

    // unit step, preset at full scale
    write_regs(make_cfg(1, 1023, 1023, 255, 1));
    send_random(60, 1'b0);
    drain();

    for (int p = 0; p < 3; p++) begin
      write_regs(make_cfg($urandom_range(0, 63), $urandom_range(0, 1023),
                          $urandom_range(0, 1023), $urandom_range(64, 255),
                          $urandom_range(0, 7)));
      send_random(70, 1'b0);
      drain();
    end

    // trip: just under, then exactly at the level; keys ignored afterwards
    write_regs(make_cfg($urandom_range(1, 63), 1023, 512, 200, 5));
    send_word(keys_word(199, 1, 0, 0, 0));
    send_word(keys_word(200, 1, 0, 0, 0));
    send_word(keys_word(0, 1, 0, 1, 0));
    send_random(80, 1'b1);
    drain();

    // lowest trip level while already latched
    write_regs(make_cfg(settings.step_size, settings.upper_limit, settings.preset_value,
                        0, settings.current_gain));
    send_random(20, 1'b1);
    drain();

    if (mismatch_count == 0 && pending_words == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
